@@ src/sobel_pkg.sv @@
// Shared types, constants and tap weight tables for the Sobel edge filter.
`default_nettype none

package sobel_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W   = 11;
  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LINE_AW = $clog2(2 * MAX_WIDTH + 4);
  localparam int TAP_W   = 4;
  localparam int WT_W    = 3;
  localparam int SUM_W   = 12;
  localparam int K_W     = 4;
  localparam int MAG_W   = 10;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  localparam logic CFG_IDX_W = 1'b0;
  localparam logic CFG_IDX_H = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [TAP_W-1:0] TAP_FIRST = TAP_W'(0);
  localparam logic [TAP_W-1:0] TAP_LAST  = TAP_W'(8);

  localparam logic [1:0] POS_LOW  = 2'd0;
  localparam logic [1:0] POS_MID  = 2'd1;
  localparam logic [1:0] POS_HIGH = 2'd2;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_res;
    logic             overflow;
    logic             frame_last;
  } out_t;

  typedef struct packed {
    logic             capture;
    logic             write;
    logic             start;
    logic             rd;
    logic             norm;
    logic             emit;
    logic [TAP_W-1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic pix_ok;
    logic pix_emit;
    logic flush_emit;
    logic out_free;
  } status_t;

  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] tap);
    logic [1:0] r;
    case (tap) inside
      4'd0, 4'd1, 4'd2: r = POS_LOW;
      4'd3, 4'd4, 4'd5: r = POS_MID;
      default:          r = POS_HIGH;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] tap);
    logic [1:0] c;
    case (tap) inside
      4'd0, 4'd3, 4'd6: c = POS_LOW;
      4'd1, 4'd4, 4'd7: c = POS_MID;
      default:          c = POS_HIGH;
    endcase
    return c;
  endfunction

  // row-difference weights, transposed kernel
  function automatic logic signed [WT_W-1:0] tap_w1(input logic [TAP_W-1:0] tap);
    logic signed [WT_W-1:0] w;
    case (tap) inside
      4'd0, 4'd2: w = -WT_W'(1);
      4'd1:       w = -WT_W'(2);
      4'd6, 4'd8: w = WT_W'(1);
      4'd7:       w = WT_W'(2);
      default:    w = '0;
    endcase
    return w;
  endfunction

  // column-difference weights, transposed kernel
  function automatic logic signed [WT_W-1:0] tap_w2(input logic [TAP_W-1:0] tap);
    logic signed [WT_W-1:0] w;
    case (tap) inside
      4'd0, 4'd6: w = WT_W'(1);
      4'd3:       w = WT_W'(2);
      4'd2, 4'd8: w = -WT_W'(1);
      4'd5:       w = -WT_W'(2);
      default:    w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ src/sobel_edge_magnitude_3x3_top.sv @@
// Top level of the streaming 3x3 Sobel edge-magnitude filter.
//
// Input channel (in_valid_i/in_ready_o, in_i): one transaction per raster pixel
// (op = pixel) or per flush item (op = flush) once the frame's pixels are in.
// Output channel (out_valid_o/out_ready_i, out_o): at most one result per input
// transaction. A pixel's result is given by the input transaction that comes
// image_width+1 pixels after it; flush transactions drain the last row.
// Configuration: cfg_we_i writes image_width (index 0) or image_height
// (index 1) and restarts the frame; write only while the block is idle.
// Sequence: a transaction without a result is captured and decided only; one
// with a result is captured, then runs decide, nine neighbour reads from the
// single-port pixel store (one per cycle), accumulate, normalize, then load
// of the output register. The nine store reads set the throughput, and no
// new transaction is taken until the current one is through.
// The output register holds a result while the receiver stalls; the block
// waits to load the next result until that register is free.
// Reset: width 640, height 480, empty frame, no result pending.
`default_nettype none

module sobel_edge_magnitude_3x3_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [sobel_pkg::DIM_W-1:0]  cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sobel_pkg::in_t               in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output sobel_pkg::out_t                   out_o
);

  sobel_pkg::cmd_t    cmd;
  sobel_pkg::status_t st;

  sobel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  sobel_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in progress");

  a_result_held_while_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)))
    else $error("result dropped or changed while stalled");

endmodule

`default_nettype wire

@@ src/sobel_ctrl.sv @@
// Controller state machine sequencing decide, tap reads, normalize and emit.
`default_nettype none

module sobel_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sobel_pkg::status_t st_i,
  output sobel_pkg::cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_READ   = 6'b000100,
    S_ACC    = 6'b001000,
    S_NORM   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [sobel_pkg::TAP_W-1:0] tap_q, tap_d;

  always_comb begin
    state_d    = state_q;
    tap_d      = tap_q;
    cmd_o      = '0;
    cmd_o.tap  = tap_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        tap_d   = sobel_pkg::TAP_FIRST;
        if (st_i.op == sobel_pkg::OP_PIXEL) begin
          if (st_i.pix_ok) begin
            cmd_o.write = 1'b1;
            if (st_i.pix_emit) begin
              cmd_o.start = 1'b1;
              state_d     = S_READ;
            end
          end
        end else if (st_i.flush_emit) begin
          cmd_o.start = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        if (tap_q == sobel_pkg::TAP_LAST) begin
          state_d = S_ACC;
        end else begin
          tap_d = tap_q + sobel_pkg::TAP_W'(1);
        end
      end
      S_ACC: begin
        state_d = S_NORM;
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tap_q   <= sobel_pkg::TAP_FIRST;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

endmodule

`default_nettype wire

@@ src/sobel_dp.sv @@
// Datapath: configuration, raster counters, pixel store, tap accumulators, output register.
`default_nettype none

module sobel_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [sobel_pkg::DIM_W-1:0]   cfg_data_i,
  input  wire sobel_pkg::in_t                in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sobel_pkg::out_t                    out_o,
  input  wire sobel_pkg::cmd_t               cmd_i,
  output sobel_pkg::status_t                 st_o
);

  localparam int LINE_DEPTH = 2 ** sobel_pkg::LINE_AW;
  localparam int RECIP3     = 683;
  localparam int RECIP3_SH  = 11;
  localparam int PROD_W     = 24;

  function automatic logic [sobel_pkg::MAG_W-1:0] norm_mag(
    input logic signed [sobel_pkg::SUM_W-1:0] s,
    input logic signed [sobel_pkg::K_W-1:0]   k
  );
    logic [sobel_pkg::SUM_W-1:0] sm;
    logic [sobel_pkg::K_W-1:0]   km;
    logic [PROD_W-1:0]           prod;
    logic [sobel_pkg::SUM_W-1:0] q;
    sm   = s[sobel_pkg::SUM_W-1] ? unsigned'(-s) : unsigned'(s);
    km   = k[sobel_pkg::K_W-1] ? unsigned'(-k) : unsigned'(k);
    prod = PROD_W'(sm) * PROD_W'(RECIP3);
    case (km)
      sobel_pkg::K_W'(2): q = sm >> 1;
      sobel_pkg::K_W'(3): q = prod[RECIP3_SH +: sobel_pkg::SUM_W];
      sobel_pkg::K_W'(4): q = sm >> 2;
      default:            q = sm;
    endcase
    return q[sobel_pkg::MAG_W-1:0];
  endfunction

  // configuration and effective frame size
  logic [sobel_pkg::DIM_W-1:0] width_q, height_q;
  logic [sobel_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [2*sobel_pkg::DIM_W-1:0] area;
  logic [sobel_pkg::CNT_W-1:0] total_q;

  always_comb begin
    if (width_q == '0) begin
      w_eff = sobel_pkg::DIM_W'(1);
    end else if (width_q > sobel_pkg::DIM_W'(sobel_pkg::MAX_WIDTH)) begin
      w_eff = sobel_pkg::DIM_W'(sobel_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = sobel_pkg::DIM_W'(1);
    end else if (height_q > sobel_pkg::DIM_W'(sobel_pkg::MAX_HEIGHT)) begin
      h_eff = sobel_pkg::DIM_W'(sobel_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    area = (2*sobel_pkg::DIM_W)'(w_eff) * (2*sobel_pkg::DIM_W)'(h_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sobel_pkg::WIDTH_RESET;
      height_q <= sobel_pkg::HEIGHT_RESET;
      total_q  <= sobel_pkg::CNT_W'(32'd640 * 32'd480);
    end else begin
      if (cfg_we_i && cfg_idx_i == sobel_pkg::CFG_IDX_W) begin
        width_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == sobel_pkg::CFG_IDX_H) begin
        height_q <= cfg_data_i;
      end
      total_q <= area[sobel_pkg::CNT_W-1:0];
    end
  end

  // captured transaction
  sobel_pkg::in_t in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_i;
    end
  end

  // raster counters
  logic [sobel_pkg::CNT_W-1:0] recv_q, recv_d, emit_q, emit_d;
  logic [sobel_pkg::COL_W-1:0] ecol_q, ecol_d;
  logic [sobel_pkg::ROW_W-1:0] erow_q, erow_d;
  logic                        frame_last;
  logic [sobel_pkg::CNT_W:0]   emit_plus_w;

  assign frame_last  = (emit_q + sobel_pkg::CNT_W'(1)) == total_q;
  assign emit_plus_w = (sobel_pkg::CNT_W+1)'(emit_q) + (sobel_pkg::CNT_W+1)'(w_eff);

  always_comb begin
    recv_d = recv_q;
    emit_d = emit_q;
    ecol_d = ecol_q;
    erow_d = erow_q;
    if (cfg_we_i || (cmd_i.emit && frame_last)) begin
      recv_d = '0;
      emit_d = '0;
      ecol_d = '0;
      erow_d = '0;
    end else begin
      if (cmd_i.write) begin
        recv_d = recv_q + sobel_pkg::CNT_W'(1);
      end
      if (cmd_i.emit) begin
        emit_d = emit_q + sobel_pkg::CNT_W'(1);
        if (sobel_pkg::DIM_W'(ecol_q) + sobel_pkg::DIM_W'(1) == w_eff) begin
          ecol_d = '0;
          erow_d = erow_q + sobel_pkg::ROW_W'(1);
        end else begin
          ecol_d = ecol_q + sobel_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_q <= '0;
      emit_q <= '0;
      ecol_q <= '0;
      erow_q <= '0;
    end else begin
      recv_q <= recv_d;
      emit_q <= emit_d;
      ecol_q <= ecol_d;
      erow_q <= erow_d;
    end
  end

  always_comb begin
    st_o.op         = in_q.op;
    st_o.pix_ok     = recv_q < total_q;
    st_o.pix_emit   = emit_plus_w < (sobel_pkg::CNT_W+1)'(recv_q);
    st_o.flush_emit = (recv_q == total_q) && (emit_q < total_q);
    st_o.out_free   = !out_valid_o || out_ready_i;
  end

  // tap address and border test
  logic [sobel_pkg::LINE_AW-1:0] row_off, col_off, rd_addr;
  logic                          row_in, col_in;
  logic [1:0]                    trow, tcol;

  always_comb begin
    trow = sobel_pkg::tap_row(cmd_i.tap);
    tcol = sobel_pkg::tap_col(cmd_i.tap);
    case (trow)
      sobel_pkg::POS_LOW: begin
        row_off = sobel_pkg::LINE_AW'(0) - sobel_pkg::LINE_AW'(w_eff);
        row_in  = erow_q != '0;
      end
      sobel_pkg::POS_HIGH: begin
        row_off = sobel_pkg::LINE_AW'(w_eff);
        row_in  = (sobel_pkg::DIM_W'(erow_q) + sobel_pkg::DIM_W'(1)) < h_eff;
      end
      default: begin
        row_off = '0;
        row_in  = 1'b1;
      end
    endcase
    case (tcol)
      sobel_pkg::POS_LOW: begin
        col_off = '1;
        col_in  = ecol_q != '0;
      end
      sobel_pkg::POS_HIGH: begin
        col_off = sobel_pkg::LINE_AW'(1);
        col_in  = (sobel_pkg::DIM_W'(ecol_q) + sobel_pkg::DIM_W'(1)) < w_eff;
      end
      default: begin
        col_off = '0;
        col_in  = 1'b1;
      end
    endcase
    rd_addr = emit_q[sobel_pkg::LINE_AW-1:0] + row_off + col_off;
  end

  // pixel store, indexed by raster position
  logic [sobel_pkg::PIX_W-1:0] line_mem_q [LINE_DEPTH];
  logic [sobel_pkg::PIX_W-1:0] rdata_q;
  logic [sobel_pkg::TAP_W-1:0] rtap_q;
  logic                        rin_q;
  logic                        rvld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      line_mem_q[recv_q[sobel_pkg::LINE_AW-1:0]] <= in_q.pixel;
    end
    if (cmd_i.rd) begin
      rdata_q <= line_mem_q[rd_addr];
      rtap_q  <= cmd_i.tap;
      rin_q   <= row_in && col_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= cmd_i.rd;
    end
  end

  // accumulate both sums and their weight totals
  logic signed [sobel_pkg::SUM_W-1:0] s1_q, s1_d, s2_q, s2_d, pix_s, term1, term2;
  logic signed [sobel_pkg::K_W-1:0]   k1_q, k1_d, k2_q, k2_d;
  logic signed [sobel_pkg::WT_W-1:0]  wt1, wt2;

  always_comb begin
    wt1   = sobel_pkg::tap_w1(rtap_q);
    wt2   = sobel_pkg::tap_w2(rtap_q);
    pix_s = signed'(sobel_pkg::SUM_W'(rdata_q));
    term1 = pix_s * sobel_pkg::SUM_W'(wt1);
    term2 = pix_s * sobel_pkg::SUM_W'(wt2);
    s1_d  = s1_q;
    s2_d  = s2_q;
    k1_d  = k1_q;
    k2_d  = k2_q;
    if (cmd_i.start) begin
      s1_d = '0;
      s2_d = '0;
      k1_d = '0;
      k2_d = '0;
    end else if (rvld_q && rin_q) begin
      s1_d = s1_q + term1;
      s2_d = s2_q + term2;
      k1_d = k1_q + sobel_pkg::K_W'(wt1);
      k2_d = k2_q + sobel_pkg::K_W'(wt2);
    end
  end

  logic [sobel_pkg::MAG_W-1:0] a1_q, a2_q;

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    k1_q <= k1_d;
    k2_q <= k2_d;
    if (cmd_i.norm) begin
      a1_q <= norm_mag(s1_q, k1_q);
      a2_q <= norm_mag(s2_q, k2_q);
    end
  end

  // edge value and output register
  logic [sobel_pkg::MAG_W:0]   mag_sum;
  logic [sobel_pkg::MAG_W-1:0] edge_v;
  logic                        out_valid_q;
  sobel_pkg::out_t             out_q;

  assign mag_sum = (sobel_pkg::MAG_W+1)'(a1_q) + (sobel_pkg::MAG_W+1)'(a2_q);
  assign edge_v  = mag_sum[sobel_pkg::MAG_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.edge_res   <= edge_v[sobel_pkg::PIX_W-1:0];
      out_q.overflow   <= |edge_v[sobel_pkg::MAG_W-1:sobel_pkg::PIX_W];
      out_q.frame_last <= frame_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

@@ verif/tb_sobel_edge_magnitude_3x3_top.sv @@
// Self-checking testbench for the streaming 3x3 Sobel edge-magnitude filter.
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_3x3_top;

  localparam int          STORE_DEPTH    = 2 * sobel_pkg::MAX_WIDTH + 4;
  localparam int unsigned RANDOM_ITEMS   = 650;
  localparam int unsigned IDLE_GAP       = 32;
  localparam int unsigned END_WAIT       = 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum logic [1:0] {PIX_NOISE, PIX_BINARY, PIX_RAMP, PIX_STEP} pix_style_e;
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic                        clk_i     = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic                        cfg_idx   = sobel_pkg::CFG_IDX_W;
  logic [sobel_pkg::DIM_W-1:0] cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  sobel_pkg::in_t              in_data   = '0;
  logic                        in_ready;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  sobel_pkg::out_t             out_data;

  wire in_fire  = in_valid & in_ready;
  wire out_fire = out_valid & out_ready;

  // predictor state
  logic [sobel_pkg::DIM_W-1:0] width_reg;
  logic [sobel_pkg::DIM_W-1:0] height_reg;
  logic [sobel_pkg::PIX_W-1:0] pix_store [STORE_DEPTH];
  int unsigned                 rx_count;
  int unsigned                 tx_count;

  sobel_pkg::out_t pending_edges [$];
  sobel_pkg::out_t want;
  int unsigned     mismatch_count = 0;
  int unsigned     active_items   = 0;
  int unsigned     burst_left     = 0;
  int unsigned     idle_cycles    = 0;
  rx_mode_e        rx_mode        = RX_FREE;
  logic [15:0]     rx_pat         = '0;
  int unsigned     rx_left        = 0;

  sobel_edge_magnitude_3x3_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned eff_dim(input logic [sobel_pkg::DIM_W-1:0] v,
                                          input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  function automatic int unsigned edge_value(input int unsigned o, input int unsigned w,
                                             input int unsigned h);
    int orow, ocol, r, c, p, wt1, wt2, s1, k1, s2, k2, g1, g2;
    orow = o / w;
    ocol = o % w;
    s1 = 0; k1 = 0; s2 = 0; k2 = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        r = orow + dy;
        c = ocol + dx;
        if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w)) begin
          p   = int'(pix_store[(r * w + c) % STORE_DEPTH]);
          wt1 = dy * ((dx == 0) ? 2 : 1);
          wt2 = -dx * ((dy == 0) ? 2 : 1);
          s1 += wt1 * p;
          k1 += wt1;
          s2 += wt2 * p;
          k2 += wt2;
        end
      end
    end
    g1 = (k1 != 0) ? s1 / k1 : s1;
    g2 = (k2 != 0) ? s2 / k2 : s2;
    if (g1 < 0) g1 = -g1;
    if (g2 < 0) g2 = -g2;
    return (g1 + g2) / 2;
  endfunction

  function automatic bit predict_edge_item(input sobel_pkg::in_t item,
                                           output sobel_pkg::out_t res, output bit taken);
    int unsigned w, h, total, v;
    w     = eff_dim(width_reg, sobel_pkg::MAX_WIDTH);
    h     = eff_dim(height_reg, sobel_pkg::MAX_HEIGHT);
    total = w * h;
    res   = '0;
    taken = 1'b0;
    if (rx_count > total) begin
      rx_count = 0;
      tx_count = 0;
    end
    if (item.op == sobel_pkg::OP_PIXEL) begin
      if (rx_count >= total) return 1'b0;
      pix_store[rx_count % STORE_DEPTH] = item.pixel;
      rx_count++;
      taken = 1'b1;
      if (tx_count + w + 1 >= rx_count) return 1'b0;
    end else begin
      if (rx_count < total || tx_count >= total) return 1'b0;
      taken = 1'b1;
    end
    v              = edge_value(tx_count, w, h);
    res.edge_res   = v[sobel_pkg::PIX_W-1:0];
    res.overflow   = (v > 255);
    res.frame_last = (tx_count + 1 == total);
    tx_count++;
    if (tx_count >= total) begin
      rx_count = 0;
      tx_count = 0;
    end
    return 1'b1;
  endfunction

  function automatic logic [sobel_pkg::PIX_W-1:0] pick_pixel(input pix_style_e style,
                                                             input int unsigned idx,
                                                             input int unsigned w);
    case (style)
      PIX_NOISE:  return sobel_pkg::PIX_W'($urandom_range(0, 255));
      PIX_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PIX_RAMP:   return sobel_pkg::PIX_W'(idx * 23 + (idx / w) * 61);
      default:    return ((idx % w) < (w + 1) / 2) ? 8'h00 : 8'hFF;
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  task automatic send_item(input logic op, input logic [sobel_pkg::PIX_W-1:0] pix);
    sobel_pkg::in_t  item;
    sobel_pkg::out_t res;
    bit              has_res;
    bit              taken;
    int unsigned     gap;
    item.op    = op;
    item.pixel = pix;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    has_res = predict_edge_item(item, res, taken);
    if (has_res) pending_edges.push_back(res);
    if (taken) active_items++;
  endtask

  task automatic drain_block(input int unsigned hold);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (hold) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [sobel_pkg::DIM_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == sobel_pkg::CFG_IDX_W) width_reg = value;
    else height_reg = value;
    rx_count = 0;
    tx_count = 0;
  endtask

  task automatic run_frame(input int unsigned keep_px);
    int unsigned w, h, total, n_px, n_flush;
    pix_style_e  style;
    w     = eff_dim(width_reg, sobel_pkg::MAX_WIDTH);
    h     = eff_dim(height_reg, sobel_pkg::MAX_HEIGHT);
    total = w * h;
    n_px  = (keep_px != 0 && keep_px < total) ? keep_px : total;
    style = pix_style_e'($urandom_range(0, 3));
    for (int unsigned i = 0; i < n_px; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(sobel_pkg::OP_FLUSH, sobel_pkg::PIX_W'($urandom));
      end
      send_item(sobel_pkg::OP_PIXEL, pick_pixel(style, i, w));
    end
    if (n_px < total) return;
    if ($urandom_range(0, 3) == 0) send_item(sobel_pkg::OP_PIXEL, sobel_pkg::PIX_W'($urandom));
    n_flush = (total < w + 1) ? total : w + 1;
    repeat (n_flush) send_item(sobel_pkg::OP_FLUSH, sobel_pkg::PIX_W'($urandom));
  endtask

  task automatic run_dims(input logic [sobel_pkg::DIM_W-1:0] w,
                          input logic [sobel_pkg::DIM_W-1:0] h,
                          input int unsigned keep_px);
    drain_block(IDLE_GAP);
    write_reg(sobel_pkg::CFG_IDX_W, w);
    write_reg(sobel_pkg::CFG_IDX_H, h);
    run_frame(keep_px);
  endtask

  task automatic test_corner_items();
    logic [sobel_pkg::PIX_W-1:0] grid [9] = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h00,
                                              8'hFF, 8'hFF, 8'h00};
    send_item(sobel_pkg::OP_PIXEL, 8'hFF);
    send_item(sobel_pkg::OP_FLUSH, 8'h00);
    send_item(sobel_pkg::OP_PIXEL, 8'h00);
    drain_block(IDLE_GAP);
    write_reg(sobel_pkg::CFG_IDX_W, sobel_pkg::DIM_W'(3));
    write_reg(sobel_pkg::CFG_IDX_H, sobel_pkg::DIM_W'(3));
    send_item(sobel_pkg::OP_FLUSH, 8'hFF);
    foreach (grid[i]) send_item(sobel_pkg::OP_PIXEL, grid[i]);
    send_item(sobel_pkg::OP_PIXEL, 8'h7F);
    repeat (4) send_item(sobel_pkg::OP_FLUSH, 8'h00);
    send_item(sobel_pkg::OP_FLUSH, 8'hA5);
    run_dims(sobel_pkg::DIM_W'(1), sobel_pkg::DIM_W'(1), 0);
  endtask

  task automatic test_frame_restart();
    drain_block(IDLE_GAP);
    write_reg(sobel_pkg::CFG_IDX_W, sobel_pkg::DIM_W'(4));
    write_reg(sobel_pkg::CFG_IDX_H, sobel_pkg::DIM_W'(3));
    run_frame(7);
    drain_block(IDLE_GAP);
    write_reg(sobel_pkg::CFG_IDX_W, sobel_pkg::DIM_W'(4));
    run_frame(0);
    run_frame(2);
    drain_block(IDLE_GAP);
    write_reg(sobel_pkg::CFG_IDX_H, sobel_pkg::DIM_W'(3));
    run_frame(0);
  endtask

  task automatic test_dim_extremes();
    run_dims(sobel_pkg::DIM_W'(0), sobel_pkg::DIM_W'(0), 0);
    run_dims(sobel_pkg::DIM_W'(1), sobel_pkg::DIM_W'(1), 0);
    run_dims(sobel_pkg::DIM_W'(2047), sobel_pkg::DIM_W'(2), sobel_pkg::MAX_WIDTH + 2);
    run_dims(sobel_pkg::DIM_W'(3), sobel_pkg::DIM_W'(2047), 20);
    run_dims(sobel_pkg::DIM_W'(0), sobel_pkg::DIM_W'(5), 0);
    run_dims(sobel_pkg::DIM_W'(6), sobel_pkg::DIM_W'(0), 0);
  endtask

  task automatic test_random_frames();
    logic [sobel_pkg::DIM_W-1:0] new_w, new_h;
    int unsigned                 frames, total;
    active_items = 0;
    while (active_items < RANDOM_ITEMS) begin
      drain_block(IDLE_GAP);
      case ($urandom_range(0, 9))
        0: begin
          new_w = '0;
          new_h = sobel_pkg::DIM_W'($urandom_range(0, 6));
        end
        1: begin
          new_w = sobel_pkg::DIM_W'($urandom_range(11, 40));
          new_h = sobel_pkg::DIM_W'($urandom_range(0, 3));
        end
        2: begin
          new_w = sobel_pkg::DIM_W'($urandom_range(1, 8));
          new_h = '0;
        end
        default: begin
          new_w = sobel_pkg::DIM_W'($urandom_range(1, 10));
          new_h = sobel_pkg::DIM_W'($urandom_range(1, 8));
        end
      endcase
      if ($urandom_range(0, 1) != 0) begin
        write_reg(sobel_pkg::CFG_IDX_W, new_w);
        if ($urandom_range(0, 3) != 0) write_reg(sobel_pkg::CFG_IDX_H, new_h);
      end else begin
        write_reg(sobel_pkg::CFG_IDX_H, new_h);
        write_reg(sobel_pkg::CFG_IDX_W, new_w);
      end
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        if ($urandom_range(0, 7) == 0) begin
          total = eff_dim(width_reg, sobel_pkg::MAX_WIDTH) *
                  eff_dim(height_reg, sobel_pkg::MAX_HEIGHT);
          run_frame($urandom_range(1, total));
          break;
        end
        run_frame(0);
      end
    end
  endtask

  task automatic close_run();
    drain_block(END_WAIT);
    if (mismatch_count == 0 && pending_edges.size() == 0) begin
      $display("tb_sobel_edge_magnitude_3x3_top OK");
    end else begin
      $display("tb_sobel_edge_magnitude_3x3_top NOT OK");
    end
    $finish;
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_pat  = 16'($urandom);
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    rx_pat = {rx_pat[14:0], rx_pat[15]};
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default:   out_ready <= rx_pat[0];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_edges.size() == 0) begin
        note_mismatch($sformatf("unexpected result edge=%0d ovf=%0b last=%0b",
                                out_data.edge_res, out_data.overflow, out_data.frame_last));
      end else begin
        want = pending_edges.pop_front();
        if (out_data.edge_res !== want.edge_res || out_data.overflow !== want.overflow ||
            out_data.frame_last !== want.frame_last) begin
          note_mismatch($sformatf({"expected edge=%0d ovf=%0b last=%0b, ",
                                   "got edge=%0d ovf=%0b last=%0b"},
                                  want.edge_res, want.overflow, want.frame_last,
                                  out_data.edge_res, out_data.overflow, out_data.frame_last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sobel_edge_magnitude_3x3_top NOT OK");
      $finish;
    end
  end

  initial begin
    width_reg  = sobel_pkg::WIDTH_RESET;
    height_reg = sobel_pkg::HEIGHT_RESET;
    rx_count   = 0;
    tx_count   = 0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_corner_items();
    test_frame_restart();
    test_dim_extremes();
    test_random_frames();
    close_run();
  end

endmodule
